>>> rtl/core/sdc_pkg.sv
// Shared widths, register codes and a saturation helper for the spring distance constraint.
package sdc_pkg;

	localparam int DATA_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;
	localparam int LEN_W      = 31;
	localparam int GAIN_W     = 17;
	localparam int GAIN_SHIFT = 16;

	localparam int DIFF_W = DATA_W + 1;
	localparam int MAG_W  = DATA_W + 1;
	localparam int SQR_W  = 2 * DATA_W + 1;
	localparam int RAD_W  = SQR_W + 1;
	localparam int DIST_W = 34;
	localparam int SQ_LAT = DIST_W;
	localparam int SQ_PAD_W = 2 * SQ_LAT;
	localparam int SQ_RW  = DIST_W + 3;

	localparam int EMAG_W = DIST_W - 1;
	localparam int MSUM_W = DATA_W + 1;
	localparam int PROD_W = MAG_W + EMAG_W;

	localparam int DIV_QW  = 35;
	localparam int DIV_DW  = 34;
	localparam int DIV_NW  = DIV_QW + DIV_DW;
	localparam int DIV_LAT = DIV_QW;

	localparam int M_W    = DIV_QW;
	localparam int NUM3_W = M_W + DATA_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REST  = 3'd0,
		REG_GAIN  = 3'd1,
		REG_MAX   = 3'd2,
		REG_MIN   = 3'd3,
		REG_BREAK = 3'd4
	} cfg_reg_t;

	// Saturate a sign and magnitude to a signed 32-bit word.
	function automatic logic [DATA_W-1:0] sat32(logic neg, logic [DIV_QW-1:0] mag);
		logic [DIV_QW-1:0] lim;
		logic [DIV_QW-1:0] nmag;
		lim  = DIV_QW'(64'h8000_0000);
		nmag = -mag;
		if (neg) begin
			sat32 = (mag > lim) ? 32'h8000_0000 : nmag[DATA_W-1:0];
		end else begin
			sat32 = (mag >= lim) ? 32'h7FFF_FFFF : mag[DATA_W-1:0];
		end
	endfunction

endpackage

>>> rtl/core/sdc_in_if.sv
// Input channel: two body positions, masses and fixed flags.
interface sdc_in_if;
	import sdc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] pos_a_x;
	logic signed [DATA_W-1:0] pos_a_y;
	logic signed [DATA_W-1:0] pos_b_x;
	logic signed [DATA_W-1:0] pos_b_y;
	logic        [DATA_W-1:0] mass_a;
	logic        [DATA_W-1:0] mass_b;
	logic                     fixed_a;
	logic                     fixed_b;

	modport source (output valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y, mass_a, mass_b,
		fixed_a, fixed_b, input ready);
	modport sink (input valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y, mass_a, mass_b,
		fixed_a, fixed_b, output ready);
endinterface

>>> rtl/core/sdc_out_if.sv
// Output channel: drags for both bodies and status flags.
interface sdc_out_if;
	import sdc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] drag_a_x;
	logic signed [DATA_W-1:0] drag_a_y;
	logic signed [DATA_W-1:0] drag_b_x;
	logic signed [DATA_W-1:0] drag_b_y;
	logic                     is_broken;
	logic                     degenerate;

	modport source (output valid, drag_a_x, drag_a_y, drag_b_x, drag_b_y, is_broken,
		degenerate, input ready);
	modport sink (input valid, drag_a_x, drag_a_y, drag_b_x, drag_b_y, is_broken,
		degenerate, output ready);
endinterface

>>> rtl/core/sdc_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module sdc_sqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [sdc_pkg::RAD_W-1:0]   rad,
	output logic [sdc_pkg::DIST_W-1:0]  root
);
	import sdc_pkg::*;

	logic [SQ_RW-1:0]    rem_q  [SQ_LAT];
	logic [DIST_W-1:0]   root_q [SQ_LAT];
	logic [SQ_PAD_W-1:0] bits_q [SQ_LAT];

	for (genvar k = 0; k < SQ_LAT; k++) begin : g_stage
		logic [SQ_RW-1:0]    rem_p;
		logic [SQ_RW-1:0]    rem_sh;
		logic [SQ_RW-1:0]    trial;
		logic [DIST_W-1:0]   root_p;
		logic [SQ_PAD_W-1:0] bits_p;
		logic                ge;

		if (k == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign bits_p = {{(SQ_PAD_W-RAD_W){1'b0}}, rad};
		end else begin : g_next
			assign rem_p  = rem_q[k-1];
			assign root_p = root_q[k-1];
			assign bits_p = bits_q[k-1];
		end

		always_comb begin
			rem_sh = {rem_p[SQ_RW-3:0], bits_p[SQ_PAD_W-1 -: 2]};
			trial  = {{(SQ_RW-DIST_W-2){1'b0}}, root_p, 2'b01};
			ge     = rem_sh >= trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
				root_q[k] <= {root_p[DIST_W-2:0], ge};
				bits_q[k] <= {bits_p[SQ_PAD_W-3:0], 2'b00};
			end
		end
	end

	assign root = root_q[SQ_LAT-1];
endmodule

>>> rtl/core/sdc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module sdc_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [sdc_pkg::DIV_NW-1:0]  num,
	input  logic [sdc_pkg::DIV_DW-1:0]  den,
	output logic [sdc_pkg::DIV_QW-1:0]  quo
);
	import sdc_pkg::*;

	logic [DIV_DW-1:0] rem_q [DIV_LAT];
	logic [DIV_QW-1:0] low_q [DIV_LAT];
	logic [DIV_DW-1:0] den_q [DIV_LAT];
	logic [DIV_QW-1:0] quo_q [DIV_LAT];

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
		logic [DIV_DW-1:0] rem_p;
		logic [DIV_QW-1:0] low_p;
		logic [DIV_DW-1:0] den_p;
		logic [DIV_QW-1:0] quo_p;
		logic [DIV_DW:0]   rem_sh;
		logic [DIV_DW:0]   diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign rem_p = num[DIV_NW-1:DIV_QW];
			assign low_p = num[DIV_QW-1:0];
			assign den_p = den;
			assign quo_p = '0;
		end else begin : g_next
			assign rem_p = rem_q[k-1];
			assign low_p = low_q[k-1];
			assign den_p = den_q[k-1];
			assign quo_p = quo_q[k-1];
		end

		always_comb begin
			rem_sh = {rem_p, low_p[DIV_QW-1]};
			diff   = rem_sh - {1'b0, den_p};
			ge     = rem_sh >= {1'b0, den_p};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
				low_q[k] <= {low_p[DIV_QW-2:0], 1'b0};
				den_q[k] <= den_p;
				quo_q[k] <= {quo_p[DIV_QW-2:0], ge};
			end
		end
	end

	assign quo = quo_q[DIV_LAT-1];
endmodule

>>> rtl/core/spring_distance_constraint.sv
// Spring distance constraint: top level with the full item pipeline.
//
// One item enters per clock unless a result is stuck at the output. Four
// stages form the difference, magnitudes, squares and radicand, a 34-stage
// square root produces the distance, two stages form the length error and the
// axis products, two 35-stage dividers scale them by 1/distance, two stages apply
// the gain and the mass weights, four 35-stage dividers split the correction by
// mass, and one stage saturates into the output register. Latency is set by the
// bit-per-stage square root and divider chains. The whole pipeline advances
// together; it holds while a result waits at the output and ready is low, so no
// item is lost or repeated. The sticky broken flag updates as items leave the
// square root, in order; configuration writes must happen only while idle.
module spring_distance_constraint (
	input  logic                            clk,
	input  logic                            arst_n,
	sdc_in_if.sink                          body,
	sdc_out_if.source                       drag,
	input  logic                            cfg_we,
	input  logic [sdc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sdc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import sdc_pkg::*;

	typedef struct packed {
		logic              neg_x;
		logic              neg_y;
		logic [MAG_W-1:0]  mag_x;
		logic [MAG_W-1:0]  mag_y;
		logic [DATA_W-1:0] mass_a;
		logic [DATA_W-1:0] mass_b;
		logic              fixed_a;
		logic              fixed_b;
	} geo_t;

	typedef struct packed {
		logic              sgn_x;
		logic              sgn_y;
		logic [DATA_W-1:0] mass_a;
		logic [DATA_W-1:0] mass_b;
		logic [MSUM_W-1:0] msum;
		logic              fixed_a;
		logic              fixed_b;
		logic              degen;
		logic              broken;
	} ctx_t;

	// configuration registers
	logic [LEN_W-1:0]  rest_q;
	logic [GAIN_W-1:0] gain_q;
	logic [LEN_W-1:0]  max_q;
	logic [LEN_W-1:0]  min_q;
	logic              brk_en_q;
	logic              broken_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q   <= LEN_W'(65536);
			gain_q   <= GAIN_W'(32768);
			max_q    <= LEN_W'(31'h7FFF_FFFF);
			min_q    <= '0;
			brk_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REST:  rest_q   <= cfg_wdata;
				REG_GAIN:  gain_q   <= cfg_wdata[GAIN_W-1:0];
				REG_MAX:   max_q    <= cfg_wdata;
				REG_MIN:   min_q    <= cfg_wdata;
				REG_BREAK: brk_en_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// advance everything together unless a result is stuck at the output
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic [SQ_LAT-1:0]  sq_v_q;
	logic [DIV_LAT-1:0] d1_v_q;
	logic [DIV_LAT-1:0] d3_v_q;

	assign en         = !v_s9 || drag.ready;
	assign body.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			sq_v_q <= '0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			d1_v_q <= '0;
			v_s7   <= 1'b0;
			v_s8   <= 1'b0;
			d3_v_q <= '0;
			v_s9   <= 1'b0;
		end else if (en) begin
			v_s1   <= body.valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			sq_v_q <= {sq_v_q[SQ_LAT-2:0], v_s4};
			v_s5   <= sq_v_q[SQ_LAT-1];
			v_s6   <= v_s5;
			d1_v_q <= {d1_v_q[DIV_LAT-2:0], v_s6};
			v_s7   <= d1_v_q[DIV_LAT-1];
			v_s8   <= v_s7;
			d3_v_q <= {d3_v_q[DIV_LAT-2:0], v_s8};
			v_s9   <= d3_v_q[DIV_LAT-1];
		end
	end

	// stage 1: position differences
	logic [DIFF_W-1:0] dx_s1, dy_s1;
	logic [DATA_W-1:0] mass_a_s1, mass_b_s1;
	logic              fixed_a_s1, fixed_b_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1      <= {body.pos_a_x[DATA_W-1], body.pos_a_x}
				- {body.pos_b_x[DATA_W-1], body.pos_b_x};
			dy_s1      <= {body.pos_a_y[DATA_W-1], body.pos_a_y}
				- {body.pos_b_y[DATA_W-1], body.pos_b_y};
			mass_a_s1  <= body.mass_a;
			mass_b_s1  <= body.mass_b;
			fixed_a_s1 <= body.fixed_a;
			fixed_b_s1 <= body.fixed_b;
		end
	end

	// stage 2: sign and magnitude
	geo_t geo_s2, geo_s3, geo_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s2.neg_x   <= dx_s1[DIFF_W-1];
			geo_s2.neg_y   <= dy_s1[DIFF_W-1];
			geo_s2.mag_x   <= dx_s1[DIFF_W-1] ? -dx_s1 : dx_s1;
			geo_s2.mag_y   <= dy_s1[DIFF_W-1] ? -dy_s1 : dy_s1;
			geo_s2.mass_a  <= mass_a_s1;
			geo_s2.mass_b  <= mass_b_s1;
			geo_s2.fixed_a <= fixed_a_s1;
			geo_s2.fixed_b <= fixed_b_s1;
		end
	end

	// stage 3: squares, stage 4: radicand
	logic [SQR_W-1:0] sqx_s3, sqy_s3;
	logic [RAD_W-1:0] rad_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s3 <= SQR_W'(geo_s2.mag_x) * SQR_W'(geo_s2.mag_x);
			sqy_s3 <= SQR_W'(geo_s2.mag_y) * SQR_W'(geo_s2.mag_y);
			geo_s3 <= geo_s2;
			rad_s4 <= RAD_W'(sqx_s3) + RAD_W'(sqy_s3);
			geo_s4 <= geo_s3;
		end
	end

	// square root with the item context running alongside
	logic [DIST_W-1:0] dist_len;
	geo_t              geo_line_q [SQ_LAT];

	sdc_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s4),
		.root (dist_len)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			geo_line_q[0] <= geo_s4;
			for (int i = 1; i < SQ_LAT; i++) begin
				geo_line_q[i] <= geo_line_q[i-1];
			end
		end
	end

	// stage 5: length error, break check, degenerate cases
	geo_t              geo_d;
	logic [DIST_W-1:0] rest_ext;
	logic              brk_hit;
	logic              eneg;
	logic [DIST_W-1:0] ediff;
	logic [MSUM_W-1:0] msum;
	logic              both_free;

	logic [MAG_W-1:0]  mag_x_s5, mag_y_s5;
	logic [EMAG_W-1:0] emag_s5;
	logic [DIST_W-1:0] den1_s5;
	ctx_t              ctx_s5, ctx_s6;

	always_comb begin
		geo_d     = geo_line_q[SQ_LAT-1];
		rest_ext  = DIST_W'(rest_q);
		brk_hit   = brk_en_q && ((dist_len > DIST_W'(max_q)) || (dist_len < DIST_W'(min_q)));
		eneg      = dist_len < rest_ext;
		ediff     = eneg ? (rest_ext - dist_len) : (dist_len - rest_ext);
		msum      = MSUM_W'(geo_d.mass_a) + MSUM_W'(geo_d.mass_b);
		both_free = !geo_d.fixed_a && !geo_d.fixed_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			broken_q <= 1'b0;
		end else if (en && sq_v_q[SQ_LAT-1]) begin
			broken_q <= broken_q | brk_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_x_s5       <= geo_d.mag_x;
			mag_y_s5       <= geo_d.mag_y;
			emag_s5        <= ediff[EMAG_W-1:0];
			den1_s5        <= (dist_len == '0) ? DIST_W'(1) : dist_len;
			ctx_s5.sgn_x   <= geo_d.neg_x != eneg;
			ctx_s5.sgn_y   <= geo_d.neg_y != eneg;
			ctx_s5.mass_a  <= geo_d.mass_a;
			ctx_s5.mass_b  <= geo_d.mass_b;
			ctx_s5.msum    <= msum;
			ctx_s5.fixed_a <= geo_d.fixed_a;
			ctx_s5.fixed_b <= geo_d.fixed_b;
			ctx_s5.degen   <= (dist_len == '0) || (both_free && (msum == '0));
			ctx_s5.broken  <= broken_q | brk_hit;
		end
	end

	// stage 6: |d| * |e| per axis
	logic [PROD_W-1:0] px_s6, py_s6;
	logic [DIST_W-1:0] den1_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s6   <= PROD_W'(mag_x_s5) * PROD_W'(emag_s5);
			py_s6   <= PROD_W'(mag_y_s5) * PROD_W'(emag_s5);
			den1_s6 <= den1_s5;
			ctx_s6  <= ctx_s5;
		end
	end

	// divide by distance
	logic [DIV_QW-1:0] m1x, m1y;
	ctx_t              ctx1_line_q [DIV_LAT];

	sdc_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (DIV_NW'(px_s6)),
		.den (DIV_DW'(den1_s6)),
		.quo (m1x)
	);

	sdc_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (DIV_NW'(py_s6)),
		.den (DIV_DW'(den1_s6)),
		.quo (m1y)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			ctx1_line_q[0] <= ctx_s6;
			for (int i = 1; i < DIV_LAT; i++) begin
				ctx1_line_q[i] <= ctx1_line_q[i-1];
			end
		end
	end

	// stage 7: apply the Q1.16 gain
	logic [M_W+GAIN_W-1:0] gx, gy;
	logic [M_W-1:0]        m2x_s7, m2y_s7;
	ctx_t                  ctx_s7, ctx_s8;

	always_comb begin
		gx = (M_W+GAIN_W)'(m1x) * (M_W+GAIN_W)'(gain_q);
		gy = (M_W+GAIN_W)'(m1y) * (M_W+GAIN_W)'(gain_q);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m2x_s7 <= gx[M_W+GAIN_SHIFT-1:GAIN_SHIFT];
			m2y_s7 <= gy[M_W+GAIN_SHIFT-1:GAIN_SHIFT];
			ctx_s7 <= ctx1_line_q[DIV_LAT-1];
		end
	end

	// stage 8: mass weights; a lone free body takes the full correction (x1/1)
	logic              free2;
	logic [DATA_W-1:0] mult_a, mult_b;
	logic [NUM3_W-1:0] nax_s8, nay_s8, nbx_s8, nby_s8;
	logic [DIV_DW-1:0] den3_s8;

	always_comb begin
		free2  = !ctx_s7.fixed_a && !ctx_s7.fixed_b;
		mult_a = free2 ? ctx_s7.mass_b : DATA_W'(1);
		mult_b = free2 ? ctx_s7.mass_a : DATA_W'(1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nax_s8  <= NUM3_W'(m2x_s7) * NUM3_W'(mult_a);
			nay_s8  <= NUM3_W'(m2y_s7) * NUM3_W'(mult_a);
			nbx_s8  <= NUM3_W'(m2x_s7) * NUM3_W'(mult_b);
			nby_s8  <= NUM3_W'(m2y_s7) * NUM3_W'(mult_b);
			den3_s8 <= (free2 && (ctx_s7.msum != '0)) ? DIV_DW'(ctx_s7.msum)
				: DIV_DW'(1);
			ctx_s8  <= ctx_s7;
		end
	end

	// divide by the mass sum
	logic [DIV_QW-1:0] qax, qay, qbx, qby;
	ctx_t              ctx3_line_q [DIV_LAT];

	sdc_div u_div_ax (.clk(clk), .en(en), .num(DIV_NW'(nax_s8)), .den(den3_s8), .quo(qax));
	sdc_div u_div_ay (.clk(clk), .en(en), .num(DIV_NW'(nay_s8)), .den(den3_s8), .quo(qay));
	sdc_div u_div_bx (.clk(clk), .en(en), .num(DIV_NW'(nbx_s8)), .den(den3_s8), .quo(qbx));
	sdc_div u_div_by (.clk(clk), .en(en), .num(DIV_NW'(nby_s8)), .den(den3_s8), .quo(qby));

	always_ff @(posedge clk) begin
		if (en) begin
			ctx3_line_q[0] <= ctx_s8;
			for (int i = 1; i < DIV_LAT; i++) begin
				ctx3_line_q[i] <= ctx3_line_q[i-1];
			end
		end
	end

	// stage 9: drop drags of fixed bodies and degenerate items, set signs, saturate
	ctx_t              ctx_f;
	logic              move_a, move_b;
	logic [DATA_W-1:0] ax_s9, ay_s9, bx_s9, by_s9;
	logic              brk_s9, degen_s9;

	always_comb begin
		ctx_f  = ctx3_line_q[DIV_LAT-1];
		move_a = !ctx_f.fixed_a && !ctx_f.degen;
		move_b = !ctx_f.fixed_b && !ctx_f.degen;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s9    <= sat32(!ctx_f.sgn_x, move_a ? qax : '0);
			ay_s9    <= sat32(!ctx_f.sgn_y, move_a ? qay : '0);
			bx_s9    <= sat32(ctx_f.sgn_x, move_b ? qbx : '0);
			by_s9    <= sat32(ctx_f.sgn_y, move_b ? qby : '0);
			brk_s9   <= ctx_f.broken;
			degen_s9 <= ctx_f.degen;
		end
	end

	assign drag.valid      = v_s9;
	assign drag.drag_a_x   = ax_s9;
	assign drag.drag_a_y   = ay_s9;
	assign drag.drag_b_x   = bx_s9;
	assign drag.drag_b_y   = by_s9;
	assign drag.is_broken  = brk_s9;
	assign drag.degenerate = degen_s9;

`ifndef SYNTHESIS
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		drag.valid && drag.degenerate |-> (drag.drag_a_x == '0) && (drag.drag_a_y == '0)
			&& (drag.drag_b_x == '0) && (drag.drag_b_y == '0))
		else $error("degenerate item carries a nonzero drag");

	a_broken_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		broken_q |=> broken_q)
		else $error("broken latch cleared without reset");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!body.ready |-> drag.valid && !drag.ready)
		else $error("input stalled without a blocked result");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		drag.valid && !drag.ready |=> drag.valid && $stable(ax_s9) && $stable(bx_s9))
		else $error("waiting result changed");
`endif
endmodule
